[src/tlb_pkg.sv]
`default_nettype none
package tlb_pkg;

    // Input item kinds (s_tuser)
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_IDLE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result kinds (m_tuser)
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_IDLE = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_TERM_LENGTH  = 2'd1;
    localparam logic [1:0] REG_TERM_BYTES   = 2'd2;

    localparam logic [31:0] RST_IDLE_TIMEOUT = 32'd100;
    localparam logic [2:0]  RST_TERM_LENGTH  = 3'd2;
    localparam logic [31:0] RST_TERM_BYTES   = 32'h0000_0A0D;

    // Width of the terminator register, in bytes
    localparam int TERM_BYTES = 4;

    typedef struct packed {
        logic [31:0] idle_timeout_ms;
        logic [2:0]  terminator_length;
        logic [31:0] terminator_bytes;
    } cfg_t;

endpackage
`default_nettype wire

[src/tlb_ram.sv]
`default_nettype none
module tlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[src/tlb_queue.sv]
`default_nettype none
module tlb_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  push_data,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[src/tlb_front.sv]
`default_nettype none
module tlb_front #(
    parameter int STORE_DEPTH    = 64,
    parameter int MAX_TERMINATOR = 4
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire tlb_pkg::cfg_t               cfg,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [39:0]                       s_tdata,
    input  wire [1:0]                        s_tuser,
    output logic                             ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0]   ram_waddr,
    output logic [7:0]                       ram_wdata,
    output logic                             cmd_push,
    output logic [$clog2(STORE_DEPTH)+$clog2(STORE_DEPTH+1)+1:0] cmd_data,
    input  wire                              cmd_full,
    input  wire                              release_byte
);

    import tlb_pkg::*;

    localparam int PTR_W    = $clog2(STORE_DEPTH);
    localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int TERM_CAP = (MAX_TERMINATOR < TERM_BYTES) ? MAX_TERMINATOR : TERM_BYTES;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [31:0]      recent_reg, recent_next;
    logic [31:0]      last_ms_reg, last_ms_next;

    logic [1:0]       op;
    logic [7:0]       data_byte;
    logic [31:0]      now_ms;
    logic             accept;
    logic             store_full;
    logic             no_slot;
    logic [CNT_W-1:0] fill_w;
    logic [31:0]      recent_w;
    logic [2:0]       tlen;
    logic             match;
    logic [TERM_BYTES-1:0][7:0] term_b;
    logic [1:0]       want_idx;
    logic [31:0]      elapsed;
    logic [PTR_W-1:0] cmd_ptr;
    logic [CNT_W-1:0] cmd_cnt;
    logic [1:0]       cmd_kind;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(n);
        if (s >= SUM_W'(STORE_DEPTH))
        begin
            s = s - SUM_W'(STORE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    assign op        = s_tuser;
    assign data_byte = s_tdata[7:0];
    assign now_ms    = s_tdata[39:8];

    assign store_full = (fill_reg == CNT_W'(STORE_DEPTH));
    // A new byte must not land on a slot the back end has not read out yet
    assign no_slot    = !store_full &&
                        ((SUM_W'(fill_reg) + SUM_W'(held_reg)) >= SUM_W'(STORE_DEPTH));
    assign s_tready   = !cmd_full && !((op == OP_WRITE) && no_slot);
    assign accept     = s_tvalid && s_tready;

    assign fill_w   = fill_reg + 1'b1;
    assign recent_w = {recent_reg[23:0], data_byte};
    assign term_b   = cfg.terminator_bytes;
    assign elapsed  = now_ms - last_ms_reg;

    always_comb
    begin
        tlen = cfg.terminator_length;
        if (tlen == 3'd0)
        begin
            tlen = 3'd1;
        end
        if (tlen > 3'(TERM_CAP))
        begin
            tlen = 3'(TERM_CAP);
        end
    end

    // Newest byte sits in recent bits 7:0 and faces the terminator's last byte
    always_comb
    begin
        match    = (SUM_W'(fill_w) >= SUM_W'(tlen));
        want_idx = '0;
        for (int k = 0; k < TERM_BYTES; k++)
        begin
            if (3'(k) < tlen)
            begin
                want_idx = 2'(tlen - 3'd1 - 3'(k));
                if (recent_w[8*k +: 8] != term_b[want_idx])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        fill_next    = fill_reg;
        recent_next  = recent_reg;
        last_ms_next = last_ms_reg;
        ram_we       = 1'b0;
        ram_waddr    = wrap_add(rd_ptr_reg, fill_reg);
        ram_wdata    = data_byte;
        cmd_push     = 1'b0;
        cmd_ptr      = rd_ptr_reg;
        cmd_cnt      = fill_reg;
        cmd_kind     = KIND_LINE;
        if (accept)
        begin
            unique case (op)
                OP_WRITE:
                begin
                    if (store_full)
                    begin
                        cmd_push = 1'b1;
                        cmd_cnt  = CNT_W'(1);
                        cmd_kind = KIND_DROP;
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        recent_next  = recent_w;
                        last_ms_next = now_ms;
                        if (match)
                        begin
                            cmd_push    = 1'b1;
                            cmd_cnt     = fill_w;
                            rd_ptr_next = wrap_add(rd_ptr_reg, fill_w);
                            fill_next   = '0;
                        end
                        else
                        begin
                            fill_next = fill_w;
                        end
                    end
                end
                OP_IDLE:
                begin
                    if ((elapsed >= cfg.idle_timeout_ms) && (fill_reg != '0))
                    begin
                        cmd_push    = 1'b1;
                        cmd_kind    = KIND_IDLE;
                        rd_ptr_next = wrap_add(rd_ptr_reg, fill_reg);
                        fill_next   = '0;
                    end
                end
                OP_CLEAR:
                begin
                    // Discard stored bytes; keep the slot position so the free
                    // space stays contiguous with the bytes still owed
                    fill_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        held_next = held_reg;
        if (cmd_push && (cmd_kind != KIND_DROP))
        begin
            held_next = held_next + cmd_cnt;
        end
        if (release_byte)
        begin
            held_next = held_next - 1'b1;
        end
    end

    assign cmd_data = {cmd_kind, cmd_cnt, cmd_ptr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            held_reg    <= '0;
            recent_reg  <= '0;
            last_ms_reg <= '0;
        end
        else
        begin
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            held_reg    <= held_next;
            recent_reg  <= recent_next;
            last_ms_reg <= last_ms_next;
        end
    end

endmodule
`default_nettype wire

[src/tlb_back.sv]
`default_nettype none
module tlb_back #(
    parameter int STORE_DEPTH = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cmd_empty,
    input  wire [$clog2(STORE_DEPTH)+$clog2(STORE_DEPTH+1)+1:0] cmd_data,
    output logic                             cmd_pop,
    output logic                             ram_re,
    output logic [$clog2(STORE_DEPTH)-1:0]   ram_raddr,
    input  wire [7:0]                        ram_rdata,
    output logic                             release_byte,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,
    output logic                             m_tlast,
    output logic [1:0]                       m_tuser
);

    import tlb_pkg::*;

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic             busy_reg, busy_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [1:0]       kind_reg, kind_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic [1:0]       pend_kind_reg, pend_kind_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic [1:0]       out_kind_reg, out_kind_next;

    logic             issue;
    logic [PTR_W-1:0] q_ptr;
    logic [CNT_W-1:0] q_cnt;
    logic [1:0]       q_kind;

    assign {q_kind, q_cnt, q_ptr} = cmd_data;

    assign cmd_pop      = !busy_reg && !cmd_empty;
    // Launch one read while the output slot is free or being taken
    assign issue        = busy_reg && !pend_reg && (!out_valid_reg || m_tready);
    assign ram_re       = issue && (kind_reg != KIND_DROP);
    assign ram_raddr    = ptr_reg;
    assign release_byte = ram_re;

    always_comb
    begin
        busy_next      = busy_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        kind_next      = kind_reg;
        pend_next      = issue;
        pend_last_next = pend_last_reg;
        pend_kind_next = pend_kind_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_kind_next  = out_kind_reg;

        if (cmd_pop)
        begin
            busy_next = 1'b1;
            ptr_next  = q_ptr;
            left_next = q_cnt;
            kind_next = q_kind;
        end

        if (issue)
        begin
            pend_last_next = (left_reg == CNT_W'(1));
            pend_kind_next = kind_reg;
            ptr_next       = (ptr_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            left_next      = left_reg - 1'b1;
            if (left_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = (pend_kind_reg == KIND_DROP) ? 8'd0 : ram_rdata;
            out_last_next  = pend_last_reg;
            out_kind_next  = pend_kind_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        left_reg      <= left_next;
        kind_reg      <= kind_next;
        pend_last_reg <= pend_last_next;
        pend_kind_reg <= pend_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_kind_reg  <= out_kind_next;
    end

endmodule
`default_nettype wire

[src/terminated_line_buffer.sv]
`default_nettype none
// Line framer over a circular byte store. Each input beat is a byte write,
// an idle check or a clear (s_tuser). Bytes collect in the store; as soon as
// the stored bytes end with the configured terminator the whole line is sent
// out as a run of beats (m_tlast on the final one, m_tuser = 0). An idle
// check whose time since the last stored byte has reached idle_timeout_ms
// sends the partial line (m_tuser = 1). A write into a full store sends one
// drop report beat (byte 0, m_tuser = 2). Input beats are taken one per cycle
// while s_tready is high; each flushed line is handed to the back end as one
// command through a four-entry queue. The back end reads the store through
// its one registered read port and does not launch a new read while one is
// still pending. Input stalls only when that queue is full, or when a byte
// would overwrite a slot still waiting to be sent.
// Configuration registers (APB, 32-bit): 0x0 idle_timeout_ms,
// 0x4 terminator_length, 0x8 terminator_bytes (first byte in bits 7:0).
module terminated_line_buffer #(
    parameter int STORE_DEPTH    = 64,
    parameter int MAX_TERMINATOR = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    // APB configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [7:0] data_byte, [39:8] now_ms
    input  wire  [1:0]  s_tuser,   // [1:0] operation
    // Output stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // out_last
    output logic [1:0]  m_tuser    // [1:0] out_kind
);

    import tlb_pkg::*;

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    // Queue entry: kind, byte count, start slot
    localparam int CMD_W = PTR_W + CNT_W + 2;

    cfg_t             cfg_reg, cfg_next;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    logic             cmd_push;
    logic [CMD_W-1:0] cmd_in;
    logic             cmd_full;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_out;
    logic             cmd_empty;
    logic             release_byte;

    // Register file: write on the access cycle, no wait states
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_IDLE_TIMEOUT: cfg_next.idle_timeout_ms   = pwdata;
                REG_TERM_LENGTH:  cfg_next.terminator_length = pwdata[2:0];
                REG_TERM_BYTES:   cfg_next.terminator_bytes  = pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IDLE_TIMEOUT: prdata = cfg_reg.idle_timeout_ms;
            REG_TERM_LENGTH:  prdata = {29'd0, cfg_reg.terminator_length};
            REG_TERM_BYTES:   prdata = cfg_reg.terminator_bytes;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout_ms   <= RST_IDLE_TIMEOUT;
            cfg_reg.terminator_length <= RST_TERM_LENGTH;
            cfg_reg.terminator_bytes  <= RST_TERM_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: take beats, update the store, classify flushes
    tlb_front #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_TERMINATOR (MAX_TERMINATOR)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in),
        .cmd_full     (cmd_full),
        .release_byte (release_byte)
    );

    // Line store
    tlb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Flush commands between front and back
    tlb_queue #(
        .WIDTH (CMD_W),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    // Back end: walk the store and drive the output stream
    tlb_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd_data     (cmd_out),
        .cmd_pop      (cmd_pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .release_byte (release_byte),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule
`default_nettype wire

[sim/terminated_line_buffer_tb.sv]
`timescale 1ns / 1ps

module terminated_line_buffer_tb;
    import tlb_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int STORE_DEPTH = 64;
    // Operation code 3 has no meaning; the block must ignore it
    localparam logic [1:0] OP_NONE = 2'd3;
    // Cycles to let the back end run dry before touching the registers
    localparam int QUIET_CYCLES = 40;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [31:0] now_ms;
    } link_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] kind;
    } line_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // [7:0] data_byte, [39:8] now_ms
    logic [1:0]  s_tuser = '0;     // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;          // [1:0] out_kind

    terminated_line_buffer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Items waiting to go out on the input stream, and line bytes the
    // framer is owed on the output stream
    link_item_t link_items[$];
    line_beat_t bytes_due[$];

    // Shadow of the framer: register copies and store state
    logic [31:0] cfg_timeout = RST_IDLE_TIMEOUT;
    logic [2:0]  cfg_tlen    = RST_TERM_LENGTH;
    logic [31:0] cfg_tbytes  = RST_TERM_BYTES;
    logic [7:0]  line_mem[STORE_DEPTH];
    logic [5:0]  rd_ptr = '0;
    logic [6:0]  fill_cnt = '0;
    logic [31:0] recent = '0;
    logic [31:0] last_ms = '0;

    // Stimulus time keeping: running clock and the time of the last write queued
    logic [31:0] ms_now = '0;
    logic [31:0] gen_last = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic in_took = 1'b0;

    int fail_count = 0;
    int items_queued = 0;
    int beats_in = 0;
    int beats_out = 0;
    int lines_out = 0;
    int flushes_out = 0;
    int drops_out = 0;
    int reg_reads = 0;

    function automatic void note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // Terminator length as the framer applies it: zero counts as one,
    // anything past the register width in bytes counts as the maximum
    function automatic int term_count();
        if (cfg_tlen == 3'd0)
            return 1;
        if (cfg_tlen > TERM_BYTES)
            return TERM_BYTES;
        return cfg_tlen;
    endfunction

    // Hand the whole stored line to the output, oldest byte first
    task automatic flush_line(input logic [1:0] kind);
        line_beat_t beat;
        int k;
        for (k = 0; k < fill_cnt; k++)
        begin
            beat.data = line_mem[rd_ptr + k[5:0]];
            beat.last = (k + 1 == fill_cnt);
            beat.kind = kind;
            bytes_due.push_back(beat);
        end
        rd_ptr = rd_ptr + fill_cnt[5:0];
        fill_cnt = '0;
    endtask

    // Advance the shadow framer by one accepted input beat
    task automatic framer_step(input logic [1:0] op, input logic [7:0] b,
                               input logic [31:0] now);
        line_beat_t drop;
        logic [31:0] elapsed;
        int n;
        int k;
        bit hit;
        case (op)
            OP_WRITE:
            begin
                if (fill_cnt >= STORE_DEPTH)
                begin
                    // Full store: report the drop, keep time and history
                    drop.data = 8'h00;
                    drop.last = 1'b1;
                    drop.kind = KIND_DROP;
                    bytes_due.push_back(drop);
                end
                else
                begin
                    line_mem[rd_ptr + fill_cnt[5:0]] = b;
                    fill_cnt++;
                    last_ms = now;
                    recent = {recent[23:0], b};
                    // Newest byte must equal the last terminator byte, and so on
                    n = term_count();
                    hit = (fill_cnt >= n);
                    for (k = 0; k < n; k++)
                        if (recent[8 * k +: 8] != cfg_tbytes[8 * (n - 1 - k) +: 8])
                            hit = 1'b0;
                    if (hit)
                        flush_line(KIND_LINE);
                end
            end
            OP_IDLE:
            begin
                elapsed = now - last_ms;
                if (elapsed >= cfg_timeout && fill_cnt != 0)
                    flush_line(KIND_IDLE);
            end
            OP_CLEAR:
            begin
                rd_ptr = '0;
                fill_cnt = '0;
            end
            default: ;
        endcase
    endtask

    // Input driver: move to the next item once the current beat is taken,
    // idling at random between items
    always @(negedge clk)
    begin : feed
        link_item_t it;
        if (!s_tvalid || in_took)
        begin
            if (link_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                it = link_items.pop_front();
                s_tdata  <= {it.now_ms, it.data};
                s_tuser  <= it.op;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Monitor: predict from every accepted input beat, then check every
    // accepted output beat against the oldest prediction
    always @(posedge clk)
    begin : watch
        line_beat_t want;
        in_took <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            beats_in++;
            framer_step(s_tuser, s_tdata[7:0], s_tdata[39:8]);
        end
        if (m_tvalid && m_tready)
        begin
            beats_out++;
            if (m_tlast)
            begin
                if (m_tuser == KIND_LINE)
                    lines_out++;
                else if (m_tuser == KIND_IDLE)
                    flushes_out++;
                else if (m_tuser == KIND_DROP)
                    drops_out++;
            end
            if (bytes_due.size() == 0)
                note_fail($sformatf("output beat %0d with nothing due: byte %02h last %0b kind %0d",
                                    beats_out, m_tdata, m_tlast, m_tuser));
            else
            begin
                want = bytes_due.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.kind)
                    note_fail($sformatf({"output beat %0d mismatch: expected byte %02h last %0b ",
                                         "kind %0d, got byte %02h last %0b kind %0d"},
                                        beats_out, want.data, want.last, want.kind,
                                        m_tdata, m_tlast, m_tuser));
            end
        end
    end

    // Register read over APB, compared against the expected value
    task automatic reg_expect(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        reg_reads++;
        if (got !== want)
            note_fail($sformatf("register %0d reads %08h, expected %08h", idx, got, want));
    endtask

    // Register write over APB; update the shadow copy and read it back
    task automatic reg_set(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_IDLE_TIMEOUT: cfg_timeout = val;
            REG_TERM_LENGTH:  cfg_tlen = val[2:0];
            REG_TERM_BYTES:   cfg_tbytes = val;
            default: ;
        endcase
        reg_expect(idx, (idx == REG_TERM_LENGTH) ? {29'd0, val[2:0]} : val);
    endtask

    task automatic push_item(input logic [1:0] op, input logic [7:0] b,
                             input logic [31:0] now);
        link_item_t it;
        it.op = op;
        it.data = b;
        it.now_ms = now;
        link_items.push_back(it);
        if (op != OP_NONE)
            items_queued++;
    endtask

    task automatic add_write(input logic [7:0] b);
        ms_now = ms_now + $urandom_range(0, 3);
        push_item(OP_WRITE, b, ms_now);
        gen_last = ms_now;
    endtask

    // Idle check aimed around the timeout boundary of the last write
    task automatic add_probe();
        logic [31:0] t;
        case ($urandom_range(0, 4))
            0:       t = gen_last + cfg_timeout - 32'd1;
            1:       t = gen_last + cfg_timeout;
            2:       t = gen_last + cfg_timeout + $urandom_range(1, 5000);
            3:       t = $urandom;
            default: t = gen_last + $urandom_range(0, 3);
        endcase
        ms_now = t;
        push_item(OP_IDLE, $urandom_range(0, 255), t);
    endtask

    // Random body followed by the full terminator
    task automatic add_line(input int body);
        int k;
        for (k = 0; k < body; k++)
            add_write($urandom_range(0, 255));
        for (k = 0; k < term_count(); k++)
            add_write(cfg_tbytes[8 * k +: 8]);
    endtask

    // Fill the store past its depth without ever closing a line, then
    // recover by an idle flush or a clear
    task automatic add_overflow();
        logic [7:0] avoid;
        logic [7:0] b;
        int k;
        int total;
        avoid = cfg_tbytes[8 * (term_count() - 1) +: 8];
        push_item(OP_CLEAR, $urandom_range(0, 255), ms_now);
        total = STORE_DEPTH + $urandom_range(1, 3);
        for (k = 0; k < total; k++)
        begin
            do
                b = $urandom_range(0, 255);
            while (b == avoid);
            add_write(b);
        end
        if ($urandom_range(0, 1) == 1)
            push_item(OP_IDLE, $urandom_range(0, 255), gen_last + cfg_timeout);
        else
            push_item(OP_CLEAR, $urandom_range(0, 255), ms_now);
    endtask

    // Half well-formed lines with random content; the rest partial and
    // broken lines, idle checks, clears, raw noise and store overflows
    task automatic add_traffic(input int goal, input bit with_overflow);
        int pick;
        int k;
        if (with_overflow)
            add_overflow();
        while (items_queued < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                add_line(($urandom_range(0, 9) == 0) ? $urandom_range(20, 58)
                                                     : $urandom_range(0, 10));
            else if (pick < 65)
            begin
                // Partial line, sometimes a terminator cut one byte short
                for (k = $urandom_range(1, 8); k > 0; k--)
                    add_write($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1)
                    for (k = 0; k < term_count() - 1; k++)
                        add_write(cfg_tbytes[8 * k +: 8]);
                add_probe();
                if ($urandom_range(0, 1) == 1)
                    add_probe();
            end
            else if (pick < 75)
                add_probe();
            else if (pick < 83)
            begin
                for (k = $urandom_range(0, 4); k > 0; k--)
                    add_write($urandom_range(0, 255));
                push_item(OP_CLEAR, $urandom_range(0, 255), $urandom);
            end
            else if (pick < 97)
                push_item($urandom_range(0, 3), $urandom_range(0, 255), $urandom);
            else
                add_overflow();
        end
    endtask

    // Wait for the input queue to drain and the owed bytes to arrive,
    // then hold off long enough for the back end to go quiet
    task automatic settle(input int bound);
        int waited;
        waited = 0;
        @(posedge clk);
        while (link_items.size() != 0 || s_tvalid)
            @(posedge clk);
        @(negedge clk);
        while (bytes_due.size() != 0 && waited < bound)
        begin
            @(negedge clk);
            waited++;
        end
        if (bytes_due.size() != 0)
        begin
            note_fail($sformatf("%0d line bytes never arrived", bytes_due.size()));
            fail_count += bytes_due.size() - 1;
            bytes_due.delete();
        end
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Registers come up at their reset values
        reg_expect(REG_IDLE_TIMEOUT, RST_IDLE_TIMEOUT);
        reg_expect(REG_TERM_LENGTH, {29'd0, RST_TERM_LENGTH});
        reg_expect(REG_TERM_BYTES, RST_TERM_BYTES);

        // Directed pass on the reset terminator (CR LF), clock near the wrap
        @(posedge clk);
        ms_now = 32'hFFFF_FFF0;
        add_write(8'h41);
        add_write(8'h0D);
        add_write(8'h0A);                                   // closes a line
        add_write(8'h00);
        add_write(8'hFF);
        push_item(OP_IDLE, 8'h00, gen_last + 32'd99);       // one short of timeout
        push_item(OP_IDLE, 8'hFF, gen_last + 32'd100);      // flush across the wrap
        push_item(OP_IDLE, 8'h00, gen_last + 32'd5000);     // nothing stored
        add_write(8'h0D);
        push_item(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        add_write(8'h0A);                                   // CR was cleared: no match
        push_item(OP_NONE, 8'hFF, 32'hFFFF_FFFF);           // ignored operation
        add_write(8'h0D);
        add_write(8'h0A);                                   // line of LF CR LF
        add_write(8'h55);
        push_item(OP_IDLE, 8'hAA, gen_last - 32'd1);        // elapsed wraps to maximum
        add_traffic(items_queued + 34, 1'b0);
        settle(20000);

        for (phase = 1; phase <= 6; phase++)
        begin
            case (phase)
                1:
                begin
                    reg_set(REG_IDLE_TIMEOUT, 32'd0);
                    reg_set(REG_TERM_LENGTH, 32'd1);
                    reg_set(REG_TERM_BYTES, 32'd0);
                end
                2:
                begin
                    reg_set(REG_IDLE_TIMEOUT, 32'hFFFF_FFFF);
                    reg_set(REG_TERM_LENGTH, 32'd4);
                    reg_set(REG_TERM_BYTES, 32'hFFFF_FFFF);
                end
                3:
                begin
                    reg_set(REG_IDLE_TIMEOUT, $urandom_range(1, 20));
                    reg_set(REG_TERM_LENGTH, 32'hFFFF_FFFF);  // clamps to four
                    reg_set(REG_TERM_BYTES, $urandom);
                end
                4:
                begin
                    reg_set(REG_IDLE_TIMEOUT, $urandom_range(0, 300));
                    reg_set(REG_TERM_LENGTH, 32'd0);          // counts as one
                    reg_set(REG_TERM_BYTES, $urandom);
                end
                5:
                begin
                    reg_set(REG_IDLE_TIMEOUT, $urandom_range(1, 2000));
                    reg_set(REG_TERM_LENGTH, 32'd3);
                    reg_set(REG_TERM_BYTES, $urandom);
                end
                default:
                begin
                    reg_set(REG_IDLE_TIMEOUT, $urandom);
                    reg_set(REG_TERM_LENGTH, 32'd5);          // counts as four
                    reg_set(REG_TERM_BYTES, $urandom);
                end
            endcase

            // Switch the idling mix at a rising edge so the drivers see it cleanly
            @(posedge clk);
            case (phase)
                1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2, 6:    begin send_idle_pct = 0;  recv_stall_pct = 81; end
                3, 5:    begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            add_traffic(items_queued + 34, (phase == 2 || phase == 5));
            settle(20000);
        end

        $display("covered %0d input beats over 7 register settings, %0d register reads",
                 beats_in, reg_reads);
        $display("seen %0d output beats: %0d lines, %0d idle flushes, %0d drop reports",
                 beats_out, lines_out, flushes_out, drops_out);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin : watchdog
        #(CLK_PERIOD * 2000000);
        $display("run timed out with %0d items unsent, %0d bytes owed",
                 link_items.size(), bytes_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
